>>> hw/rtl/lttis_pkg.sv
// types, constants and the leg conversion function for the leg time sorter
// no dependencies; imported by leg_time_total_insertion_sorter_unit
package lttis_pkg;

   localparam int COMPETITORS_DEFAULT = 8;

   localparam int HRS_IN_W = 5;
   localparam int MS_IN_W  = 6;
   localparam int LEG_W    = 17;
   localparam int SUM_W    = 18;
   localparam int NUM_W    = 6;
   localparam int HRS_W    = 7;
   localparam int MIN_W    = 6;
   localparam int SEC_W    = 6;
   localparam int REM_W    = 12;

   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN  = 60;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   // floor(2^30 / 3600): quotient is exact or one low
   localparam int HOUR_RECIP_W = 19;
   localparam int HOUR_SHIFT   = 30;
   localparam logic [HOUR_RECIP_W-1:0] HOUR_RECIP = HOUR_RECIP_W'(298261);

   // floor(2^18 / 60): quotient is exact or one low
   localparam int MIN_RECIP_W = 13;
   localparam int MIN_SHIFT   = 18;
   localparam logic [MIN_RECIP_W-1:0] MIN_RECIP = MIN_RECIP_W'(4369);

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [SUM_W-1:0] sum;
      logic [LEG_W-1:0] run;
      logic [LEG_W-1:0] cyc;
      logic [LEG_W-1:0] swim;
   } entry_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SUM   = 5'b00010,
      ST_SHIFT = 5'b00100,
      ST_EMIT  = 5'b01000,
      ST_DRAIN = 5'b10000
   } state_type;

   function automatic logic [LEG_W-1:0] leg_seconds(
      input logic [HRS_IN_W-1:0] h,
      input logic [MS_IN_W-1:0]  m,
      input logic [MS_IN_W-1:0]  s
   );
      logic [LEG_W-1:0] hh;
      logic [LEG_W-1:0] mm;
      logic [LEG_W-1:0] ss;
      hh = LEG_W'(h);
      mm = LEG_W'(m);
      ss = LEG_W'(s);
      return hh * LEG_W'(SECS_PER_HOUR) + mm * LEG_W'(SECS_PER_MIN) + ss;
   endfunction

endpackage

>>> hw/rtl/leg_time_total_insertion_sorter_unit.sv
// leg time sorter: converts three legs to seconds, stores records in a sorted
// memory by stable insertion and streams the run out in total order
// depends on lttis_pkg
//
// per item: the sum state, then one shift state per stored entry with a larger total
//    (0 .. COMPETITORS-1 of them) and the final write of the new record; each shift
//    is one memory read and one write, on separate read and write ports of the memory
// the item that completes a run then emits COMPETITORS rows, one memory read each,
//    and drains the split pipeline; each row passes rd_data_ff, e1_ff, e2_ff, e3_ff
//    and the result registers after its read, so results come one per cycle
// reset clears the state machine, arrival count and result strobes; memory holds
//    no reset value and needs no clearing pass; the receiver cannot stall
module leg_time_total_insertion_sorter_unit
   import lttis_pkg::*;
#(
   parameter int COMPETITORS = COMPETITORS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [HRS_IN_W-1:0] req_swim_hours,
   input  logic [MS_IN_W-1:0]  req_swim_minutes,
   input  logic [MS_IN_W-1:0]  req_swim_secs,
   input  logic [HRS_IN_W-1:0] req_cycle_hours,
   input  logic [MS_IN_W-1:0]  req_cycle_minutes,
   input  logic [MS_IN_W-1:0]  req_cycle_secs,
   input  logic [HRS_IN_W-1:0] req_run_hours,
   input  logic [MS_IN_W-1:0]  req_run_minutes,
   input  logic [MS_IN_W-1:0]  req_run_secs,
   output logic                rsp_valid,
   output logic [NUM_W-1:0]    rsp_entrant_number,
   output logic [LEG_W-1:0]    rsp_swim_total_secs,
   output logic [LEG_W-1:0]    rsp_cycle_total_secs,
   output logic [LEG_W-1:0]    rsp_run_total_secs,
   output logic [SUM_W-1:0]    rsp_sum_secs,
   output logic [HRS_W-1:0]    rsp_sum_hours,
   output logic [MIN_W-1:0]    rsp_sum_minutes,
   output logic [SEC_W-1:0]    rsp_sum_rem_secs,
   output logic                rsp_last_one
);

   localparam int IDX_W = $clog2(COMPETITORS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(COMPETITORS - 1);

   // record memory, kept in ascending total order
   entry_type mem [COMPETITORS];
   entry_type rd_data_ff;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] emit_addr_ff, emit_addr_in;
   entry_type        new_ff, new_in;

   logic             accept;
   logic [IDX_W-1:0] pos_dec;
   logic [SUM_W:0]   raw_sum;

   // split pipeline
   logic                v0_ff, last0_ff;
   logic                v1_ff, last1_ff;
   entry_type           e1_ff;
   logic [HRS_W-1:0]    q1_ff;
   logic                v2_ff, last2_ff;
   entry_type           e2_ff;
   logic [HRS_W-1:0]    hrs2_ff;
   logic [REM_W-1:0]    rem2_ff;
   logic                v3_ff, last3_ff;
   entry_type           e3_ff;
   logic [HRS_W-1:0]    hrs3_ff;
   logic [REM_W-1:0]    rem3_ff;
   logic [MIN_W-1:0]    q3_ff;

   logic [SUM_W+HOUR_RECIP_W-1:0] hour_prod;
   logic [SUM_W-1:0]              hour_back;
   logic [SUM_W-1:0]              hour_rem;
   logic [REM_W+MIN_RECIP_W-1:0]  min_prod;
   logic [REM_W-1:0]              min_back;
   logic [REM_W-1:0]              min_rem;

   logic                rsp_valid_ff;
   logic                rsp_last_ff;
   entry_type           rsp_entry_ff;
   logic [HRS_W-1:0]    rsp_hrs_ff;
   logic [MIN_W-1:0]    rsp_min_ff;
   logic [SEC_W-1:0]    rsp_sec_ff;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign pos_dec = pos_ff - 1'b1;
   assign raw_sum = (SUM_W+1)'(new_ff.swim) + (SUM_W+1)'(new_ff.cyc)
                  + (SUM_W+1)'(new_ff.run);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      emit_addr_in = emit_addr_ff;
      new_in       = new_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = new_ff;
      rd_en        = 1'b0;
      rd_addr      = pos_dec;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               new_in.swim = leg_seconds(req_swim_hours, req_swim_minutes, req_swim_secs);
               new_in.cyc  = leg_seconds(req_cycle_hours, req_cycle_minutes, req_cycle_secs);
               new_in.run  = leg_seconds(req_run_hours, req_run_minutes, req_run_secs);
               new_in.num  = NUM_W'(count_ff);
               pos_in      = count_ff;
               state_in    = ST_SUM;
            end
         end
         ST_SUM: begin
            new_in.sum = raw_sum[SUM_W] ? SUM_MAX : raw_sum[SUM_W-1:0];
            // fetch the neighbor below the insertion point
            rd_en      = (pos_ff != '0);
            rd_addr    = pos_dec;
            state_in   = ST_SHIFT;
         end
         ST_SHIFT: begin
            wr_en = 1'b1;
            if (pos_ff != '0 && rd_data_ff.sum > new_ff.sum) begin
               // move the larger entry up one slot, keep walking down
               wr_addr = pos_ff;
               wr_data = rd_data_ff;
               pos_in  = pos_dec;
               rd_en   = (pos_dec != '0);
               rd_addr = pos_dec - 1'b1;
            end else begin
               wr_addr = pos_ff;
               wr_data = new_ff;
               if (count_ff == LAST_IDX) begin
                  count_in     = '0;
                  emit_addr_in = '0;
                  state_in     = ST_EMIT;
               end else begin
                  count_in = count_ff + 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            rd_en        = 1'b1;
            rd_addr      = emit_addr_ff;
            emit_addr_in = emit_addr_ff + 1'b1;
            if (emit_addr_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (v3_ff && last3_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pos_ff       <= '0;
         emit_addr_ff <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         emit_addr_ff <= emit_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      new_ff <= new_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // hours by reciprocal, corrected once
   assign hour_prod = (SUM_W+HOUR_RECIP_W)'(rd_data_ff.sum)
                    * (SUM_W+HOUR_RECIP_W)'(HOUR_RECIP);
   assign hour_back = SUM_W'(q1_ff) * SUM_W'(SECS_PER_HOUR);
   assign hour_rem  = e1_ff.sum - hour_back;
   // minutes by reciprocal, corrected once
   assign min_prod  = (REM_W+MIN_RECIP_W)'(rem2_ff) * (REM_W+MIN_RECIP_W)'(MIN_RECIP);
   assign min_back  = REM_W'(q3_ff) * REM_W'(SECS_PER_MIN);
   assign min_rem   = rem3_ff - min_back;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v0_ff        <= (state_ff == ST_EMIT);
         v1_ff        <= v0_ff;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      last0_ff <= (emit_addr_ff == LAST_IDX);

      last1_ff <= last0_ff;
      e1_ff    <= rd_data_ff;
      q1_ff    <= hour_prod[HOUR_SHIFT +: HRS_W];

      last2_ff <= last1_ff;
      e2_ff    <= e1_ff;
      if (hour_rem >= SUM_W'(SECS_PER_HOUR)) begin
         hrs2_ff <= q1_ff + 1'b1;
         rem2_ff <= REM_W'(hour_rem - SUM_W'(SECS_PER_HOUR));
      end else begin
         hrs2_ff <= q1_ff;
         rem2_ff <= REM_W'(hour_rem);
      end

      last3_ff <= last2_ff;
      e3_ff    <= e2_ff;
      hrs3_ff  <= hrs2_ff;
      rem3_ff  <= rem2_ff;
      q3_ff    <= min_prod[MIN_SHIFT +: MIN_W];

      rsp_last_ff  <= last3_ff;
      rsp_entry_ff <= e3_ff;
      rsp_hrs_ff   <= hrs3_ff;
      if (min_rem >= REM_W'(SECS_PER_MIN)) begin
         rsp_min_ff <= q3_ff + 1'b1;
         rsp_sec_ff <= SEC_W'(min_rem - REM_W'(SECS_PER_MIN));
      end else begin
         rsp_min_ff <= q3_ff;
         rsp_sec_ff <= SEC_W'(min_rem);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_entrant_number   = rsp_entry_ff.num;
   assign rsp_swim_total_secs  = rsp_entry_ff.swim;
   assign rsp_cycle_total_secs = rsp_entry_ff.cyc;
   assign rsp_run_total_secs   = rsp_entry_ff.run;
   assign rsp_sum_secs         = rsp_entry_ff.sum;
   assign rsp_sum_hours        = rsp_hrs_ff;
   assign rsp_sum_minutes      = rsp_min_ff;
   assign rsp_sum_rem_secs     = rsp_sec_ff;
   assign rsp_last_one         = rsp_valid_ff && rsp_last_ff;

`ifndef SYNTHESIS
   // a sorted run streams out without gaps
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_last_ff |=> rsp_valid_ff)
      else $error("gap inside a sorted run");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |=> !rsp_valid_ff)
      else $error("result after the last of a run");

   a_insert_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT |-> pos_ff <= count_ff)
      else $error("insertion point beyond stored entries");

   a_transfer_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy && count_ff == $past(count_ff))
      else $error("accepted item did not start an insertion");
`endif

endmodule

>>> verif/tb_leg_time_total_insertion_sorter_unit.sv
// self-checking bench for leg_time_total_insertion_sorter_unit: drives race records,
// predicts the sorted standings and checks every emitted row
// depends on lttis_pkg and the sorter rtl
`timescale 1ns / 1ps

module tb_leg_time_total_insertion_sorter_unit
   import lttis_pkg::*;
();

   localparam int RUN_LEN     = COMPETITORS_DEFAULT;
   localparam int RANDOM_CNT  = 200;
   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 2 * RUN_LEN + 20;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [HRS_IN_W-1:0] swim_h;
      logic [MS_IN_W-1:0]  swim_m;
      logic [MS_IN_W-1:0]  swim_s;
      logic [HRS_IN_W-1:0] cyc_h;
      logic [MS_IN_W-1:0]  cyc_m;
      logic [MS_IN_W-1:0]  cyc_s;
      logic [HRS_IN_W-1:0] run_h;
      logic [MS_IN_W-1:0]  run_m;
      logic [MS_IN_W-1:0]  run_s;
   } race_item_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [SUM_W-1:0] total;
      logic [LEG_W-1:0] swim;
      logic [LEG_W-1:0] cyc;
      logic [LEG_W-1:0] run;
   } entrant_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [LEG_W-1:0] swim;
      logic [LEG_W-1:0] cyc;
      logic [LEG_W-1:0] run;
      logic [SUM_W-1:0] total;
      logic [HRS_W-1:0] hrs;
      logic [MIN_W-1:0] mins;
      logic [SEC_W-1:0] secs;
      logic             last;
   } standing_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [HRS_IN_W-1:0] req_swim_hours    = '0;
   logic [MS_IN_W-1:0]  req_swim_minutes  = '0;
   logic [MS_IN_W-1:0]  req_swim_secs     = '0;
   logic [HRS_IN_W-1:0] req_cycle_hours   = '0;
   logic [MS_IN_W-1:0]  req_cycle_minutes = '0;
   logic [MS_IN_W-1:0]  req_cycle_secs    = '0;
   logic [HRS_IN_W-1:0] req_run_hours     = '0;
   logic [MS_IN_W-1:0]  req_run_minutes   = '0;
   logic [MS_IN_W-1:0]  req_run_secs      = '0;
   logic                rsp_valid;
   logic [NUM_W-1:0]    rsp_entrant_number;
   logic [LEG_W-1:0]    rsp_swim_total_secs;
   logic [LEG_W-1:0]    rsp_cycle_total_secs;
   logic [LEG_W-1:0]    rsp_run_total_secs;
   logic [SUM_W-1:0]    rsp_sum_secs;
   logic [HRS_W-1:0]    rsp_sum_hours;
   logic [MIN_W-1:0]    rsp_sum_minutes;
   logic [SEC_W-1:0]    rsp_sum_rem_secs;
   logic                rsp_last_one;

   race_item_type entrant_q[$];
   standing_type  standings_q[$];
   entrant_type   board[RUN_LEN];
   int            board_fill;

   race_item_type cur_item;
   bit            holding;
   standing_type  got_row;
   standing_type  want_row;

   int total_items;
   int sent_count;
   int row_count;
   int run_count;
   int sat_count;
   int tie_count;
   int fail_count;
   int cycle_count;

   leg_time_total_insertion_sorter_unit #(
      .COMPETITORS (RUN_LEN)
   ) u_top (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_swim_hours       (req_swim_hours),
      .req_swim_minutes     (req_swim_minutes),
      .req_swim_secs        (req_swim_secs),
      .req_cycle_hours      (req_cycle_hours),
      .req_cycle_minutes    (req_cycle_minutes),
      .req_cycle_secs       (req_cycle_secs),
      .req_run_hours        (req_run_hours),
      .req_run_minutes      (req_run_minutes),
      .req_run_secs         (req_run_secs),
      .rsp_valid            (rsp_valid),
      .rsp_entrant_number   (rsp_entrant_number),
      .rsp_swim_total_secs  (rsp_swim_total_secs),
      .rsp_cycle_total_secs (rsp_cycle_total_secs),
      .rsp_run_total_secs   (rsp_run_total_secs),
      .rsp_sum_secs         (rsp_sum_secs),
      .rsp_sum_hours        (rsp_sum_hours),
      .rsp_sum_minutes      (rsp_sum_minutes),
      .rsp_sum_rem_secs     (rsp_sum_rem_secs),
      .rsp_last_one         (rsp_last_one)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [LEG_W-1:0] leg_to_secs(
      input logic [HRS_IN_W-1:0] h,
      input logic [MS_IN_W-1:0]  m,
      input logic [MS_IN_W-1:0]  s
   );
      int unsigned acc;
      acc = int'(h) * 3600 + int'(m) * 60 + int'(s);
      return acc[LEG_W-1:0];
   endfunction

   // stable insertion: only strictly larger totals move up
   task automatic rank_entrant(input race_item_type it);
      entrant_type  e;
      int unsigned  raw;
      int           pos;
      standing_type row;
      e.swim = leg_to_secs(it.swim_h, it.swim_m, it.swim_s);
      e.cyc  = leg_to_secs(it.cyc_h, it.cyc_m, it.cyc_s);
      e.run  = leg_to_secs(it.run_h, it.run_m, it.run_s);
      raw    = int'(e.swim) + int'(e.cyc) + int'(e.run);
      if (raw > int'(SUM_MAX)) begin
         raw = int'(SUM_MAX);
         sat_count++;
      end
      e.total = raw[SUM_W-1:0];
      e.num   = board_fill[NUM_W-1:0];
      pos = board_fill;
      while (pos > 0 && board[pos-1].total > e.total) begin
         board[pos] = board[pos-1];
         pos--;
      end
      board[pos] = e;
      board_fill++;
      if (board_fill == RUN_LEN) begin
         for (int k = 0; k < RUN_LEN; k++) begin
            row.num   = board[k].num;
            row.swim  = board[k].swim;
            row.cyc   = board[k].cyc;
            row.run   = board[k].run;
            row.total = board[k].total;
            row.hrs   = HRS_W'(int'(board[k].total) / 3600);
            row.mins  = MIN_W'((int'(board[k].total) % 3600) / 60);
            row.secs  = SEC_W'(int'(board[k].total) % 60);
            row.last  = (k == RUN_LEN - 1);
            if (k > 0 && board[k].total == board[k-1].total)
               tie_count++;
            standings_q.push_back(row);
         end
         board_fill = 0;
         run_count++;
      end
   endtask

   task automatic push_item(input int sh, input int sm, input int ss,
                            input int ch, input int cm, input int cs,
                            input int rh, input int rm, input int rs);
      race_item_type it;
      it.swim_h = sh[HRS_IN_W-1:0];
      it.swim_m = sm[MS_IN_W-1:0];
      it.swim_s = ss[MS_IN_W-1:0];
      it.cyc_h  = ch[HRS_IN_W-1:0];
      it.cyc_m  = cm[MS_IN_W-1:0];
      it.cyc_s  = cs[MS_IN_W-1:0];
      it.run_h  = rh[HRS_IN_W-1:0];
      it.run_m  = rm[MS_IN_W-1:0];
      it.run_s  = rs[MS_IN_W-1:0];
      entrant_q.push_back(it);
   endtask

   task automatic push_random();
      int kind;
      int v[9];
      kind = $urandom_range(0, 99);
      for (int i = 0; i < 9; i++) begin
         if (kind < 60)
            v[i] = (i % 3 == 0) ? $urandom_range(0, 23) : $urandom_range(0, 59);
         else if (kind < 75)
            v[i] = (i % 3 == 0) ? $urandom_range(0, 31) : $urandom_range(0, 63);
         else if (kind < 90)
            // small totals so equal keys show up often
            v[i] = (i % 3 == 0) ? 0 : $urandom_range(0, 2);
         else
            v[i] = (i % 3 == 0) ? $urandom_range(20, 31) : $urandom_range(40, 63);
      end
      push_item(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
   endtask

   function automatic int idle_pct();
      if (sent_count < total_items / 3)
         return 38;
      else if (sent_count < (2 * total_items) / 3)
         return 46;
      return 0;
   endfunction

   task automatic log_mismatch(input string what, input standing_type want,
                               input standing_type got);
      if (fail_count < MAX_REPORTS) begin
         $display("mismatch (%s) at cycle %0d", what, cycle_count);
         $display("  exp num=%0d legs=%0d/%0d/%0d sum=%0d split=%0d:%0d:%0d last=%0b",
                  want.num, want.swim, want.cyc, want.run, want.total,
                  want.hrs, want.mins, want.secs, want.last);
         $display("  got num=%0d legs=%0d/%0d/%0d sum=%0d split=%0d:%0d:%0d last=%0b",
                  got.num, got.swim, got.cyc, got.run, got.total,
                  got.hrs, got.mins, got.secs, got.last);
      end
      fail_count++;
   endtask

   // driver: a record stays on the bus until its transfer
   always @(posedge clock) begin
      if (reset) begin
         start   <= 1'b0;
         holding = 1'b0;
      end else begin
         if (start && !busy) begin
            rank_entrant(cur_item);
            sent_count++;
            holding = 1'b0;
         end
         if (!holding && entrant_q.size() != 0 && $urandom_range(0, 99) >= idle_pct()) begin
            cur_item = entrant_q.pop_front();
            holding  = 1'b1;
            req_swim_hours    <= cur_item.swim_h;
            req_swim_minutes  <= cur_item.swim_m;
            req_swim_secs     <= cur_item.swim_s;
            req_cycle_hours   <= cur_item.cyc_h;
            req_cycle_minutes <= cur_item.cyc_m;
            req_cycle_secs    <= cur_item.cyc_s;
            req_run_hours     <= cur_item.run_h;
            req_run_minutes   <= cur_item.run_m;
            req_run_secs      <= cur_item.run_s;
         end
         start <= holding;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         got_row = {rsp_entrant_number, rsp_swim_total_secs, rsp_cycle_total_secs,
                    rsp_run_total_secs, rsp_sum_secs, rsp_sum_hours, rsp_sum_minutes,
                    rsp_sum_rem_secs, rsp_last_one};
         row_count++;
         if (standings_q.size() == 0) begin
            log_mismatch("unexpected row", '0, got_row);
         end else begin
            want_row = standings_q.pop_front();
            if (got_row !== want_row)
               log_mismatch("field", want_row, got_row);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout: %0d rows still expected", standings_q.size());
         $display("leg_time_total_insertion_sorter_unit regression: fail");
         $finish;
      end
   end

   initial begin
      // run of extremes: zero, top of range, out-of-range saturation,
      // zero hours, out-of-range minutes and seconds, whole hour and minute
      push_item(0, 0, 0, 0, 0, 0, 0, 0, 0);
      push_item(23, 59, 59, 23, 59, 59, 23, 59, 59);
      push_item(31, 63, 63, 31, 63, 63, 31, 63, 63);
      push_item(0, 59, 59, 0, 0, 1, 0, 30, 0);
      push_item(0, 63, 63, 0, 63, 63, 0, 63, 63);
      push_item(31, 0, 0, 0, 0, 0, 0, 0, 0);
      push_item(1, 0, 0, 0, 0, 0, 0, 0, 0);
      push_item(0, 0, 59, 0, 0, 1, 0, 0, 0);
      // strictly falling totals: every insertion shifts the whole board
      for (int i = 7; i >= 0; i--)
         push_item(3 * i, 0, 0, 0, 0, 0, 0, 0, i);
      // equal totals from different leg splits must keep arrival order
      push_item(1, 1, 1, 0, 0, 0, 0, 0, 0);
      push_item(0, 1, 40, 0, 0, 0, 0, 0, 0);
      push_item(0, 0, 0, 1, 1, 1, 0, 0, 0);
      push_item(0, 61, 1, 0, 0, 0, 0, 0, 0);
      push_item(0, 0, 40, 0, 1, 0, 0, 0, 0);
      push_item(0, 0, 0, 0, 0, 0, 1, 1, 1);
      push_item(2, 0, 0, 0, 0, 0, 0, 0, 0);
      push_item(0, 0, 0, 0, 0, 0, 0, 1, 40);
      for (int i = 0; i < RANDOM_CNT; i++)
         push_random();
      total_items = entrant_q.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (entrant_q.size() != 0 || holding || standings_q.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d record transfers and %0d sorted rows over %0d runs",
               sent_count, row_count, run_count);
      $display("%0d totals saturated, %0d equal-total neighbors, %0d mismatches",
               sat_count, tie_count, fail_count);
      if (fail_count == 0)
         $display("leg_time_total_insertion_sorter_unit regression: pass");
      else
         $display("leg_time_total_insertion_sorter_unit regression: fail");
      $finish;
   end

endmodule
